FILE: rtl/core/morse_codec_assert.svh
// Assertion macros for the Morse codec checker.
// Needs no other file; each macro expands to one labeled concurrent assertion.
`ifndef MORSE_CODEC_ASSERT_SVH
`define MORSE_CODEC_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mc_pkg.sv
// Shared types, codes and Morse tables for the Morse codec.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mc_pkg;

  // Symbol limit of the decoder and the number of symbols stored.
  localparam int MAX_SYMBOLS  = 5;
  localparam int CODE_WIDTH   = 5;
  localparam int TABLE_SIZE   = 36;
  localparam int LETTER_COUNT = 26;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Mode, kind and symbol codes.
  localparam logic      MODE_ENC = 1'b0;
  localparam logic      MODE_DEC = 1'b1;
  localparam logic      KIND_ENC = 1'b0;
  localparam logic      KIND_DEC = 1'b1;
  localparam logic [1:0] SYM_DOT  = 2'd0;
  localparam logic [1:0] SYM_DASH = 2'd1;
  localparam logic [1:0] SYM_GAP  = 2'd2;

  // ASCII codes used for classification.
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_Z       = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Code lengths for A-Z then 0-9.
  localparam logic [2:0] CODE_LEN [TABLE_SIZE] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // Code patterns: symbol i sits in bit i, a dash is a one.
  localparam logic [4:0] CODE_BITS [TABLE_SIZE] = '{
    5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, 5'b00011,
    5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, 5'b00011, 5'b00001,
    5'b00111, 5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, 5'b00100,
    5'b01000, 5'b00110, 5'b01001, 5'b01101, 5'b00011,
    5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
    5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
  };

  // Command carried from the front to the back.
  typedef struct packed {
    logic       kind;
    logic [2:0] len;
    logic [4:0] bits;
    logic [7:0] char_out;
    logic       code_valid;
  } mc_cmd_t;

  // One result item as it leaves the back.
  typedef struct packed {
    logic       kind;
    logic [1:0] symbol_out;
    logic [7:0] char_out;
    logic       code_valid;
    logic       last;
  } mc_result_t;

  // Outcome of a code table search.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } mc_lookup_t;

  // Search the table for a collected code; all entries compare in parallel.
  function automatic mc_lookup_t lookup_code(logic [2:0] count, logic [4:0] bits);
    mc_lookup_t res;
    res = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (!res.valid && CODE_LEN[i] == count && CODE_BITS[i] == bits) begin
        res.valid = 1'b1;
        if (i < LETTER_COUNT) begin
          res.ch = CHAR_A + 8'(i);
        end else begin
          res.ch = CHAR_ZERO + 8'(i - LETTER_COUNT);
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/mc_queue.sv
// Short command queue between the codec front and back.
// Depends on mc_pkg for the command type and the queue depth.
module mc_queue
  import mc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  mc_cmd_t wr_data,
  output logic    rd_valid,
  input  logic    rd_ready,
  output mc_cmd_t rd_data
);

  mc_cmd_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              wr_fire;
  logic              rd_fire;

  assign wr_ready = (count < QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_fire) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_fire) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count <= count + 1'b1;
      end else if (!wr_fire && rd_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/mc_front.sv
// Front end of the Morse codec: accepts input items, classifies them and
// keeps the decoder's symbol collection. Depends on mc_pkg.
module mc_front
  import mc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] char_in,
  input  logic [1:0] symbol_in,
  output logic       push,
  input  logic       push_ready,
  output mc_cmd_t    cmd
);

  logic [2:0] symbol_count;
  logic [4:0] code_bits;
  logic       overlong;

  logic       accept;
  logic [7:0] ch_up;
  logic       is_letter;
  logic       is_digit;
  logic [5:0] idx;
  logic       is_mark;
  logic       is_sep;
  mc_lookup_t found;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign is_mark  = (symbol_in == SYM_DOT) || (symbol_in == SYM_DASH);
  assign is_sep   = (symbol_in == SYM_GAP);

  // Character classification for encode mode.
  always_comb begin
    ch_up = char_in;
    if (char_in >= CHAR_LOWER_A && char_in <= CHAR_LOWER_Z) begin
      ch_up = char_in - CASE_OFFSET;
    end
    is_letter = (ch_up >= CHAR_A) && (ch_up <= CHAR_Z);
    is_digit  = (ch_up >= CHAR_ZERO) && (ch_up <= CHAR_NINE);
    if (is_letter) begin
      idx = 6'(ch_up - CHAR_A);
    end else begin
      idx = 6'(ch_up - CHAR_ZERO) + 6'(LETTER_COUNT);
    end
  end

  assign found = lookup_code(symbol_count, code_bits);

  // Command built for the back end, and whether this item produces one.
  always_comb begin
    cmd  = '0;
    push = 1'b0;
    if (mode == MODE_ENC) begin
      cmd.kind = KIND_ENC;
      if (is_letter || is_digit) begin
        cmd.len  = CODE_LEN[idx];
        cmd.bits = CODE_BITS[idx];
        push     = accept;
      end else if (ch_up == CHAR_SPACE) begin
        push = accept;
      end
    end else begin
      cmd.kind = KIND_DEC;
      if (!overlong && found.valid) begin
        cmd.char_out   = found.ch;
        cmd.code_valid = 1'b1;
      end
      push = accept && is_sep && (symbol_count != '0);
    end
  end

  // Symbol collection of the decoder.
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      code_bits    <= '0;
      overlong     <= 1'b0;
    end else if (accept && mode == MODE_DEC) begin
      if (is_mark) begin
        if (symbol_count < 3'(MAX_SYMBOLS)) begin
          if (symbol_count < 3'(CODE_WIDTH)) begin
            code_bits <= code_bits | (5'(symbol_in[0]) << symbol_count);
          end
          symbol_count <= symbol_count + 3'd1;
        end else begin
          overlong <= 1'b1;
        end
      end else if (is_sep) begin
        symbol_count <= '0;
        code_bits    <= '0;
        overlong     <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/mc_back.sv
// Back end of the Morse codec: expands queued commands into result items,
// one per cycle while the output is not stalled, into the output register. Depends on mc_pkg.
module mc_back
  import mc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  mc_cmd_t    q_data,
  output logic       out_valid,
  input  logic       out_ready,
  output mc_result_t out_res
);

  logic       busy;
  mc_cmd_t    cmd;
  logic [2:0] pos;

  logic       out_free;
  logic       fire;
  mc_cmd_t    cur;
  logic [2:0] cur_pos;
  mc_result_t res;

  assign out_free = !out_valid || out_ready;
  assign cur      = busy ? cmd : q_data;
  assign cur_pos  = busy ? pos : 3'd0;
  assign fire     = out_free && (busy || q_valid);
  assign q_ready  = fire && !busy;

  // Next result of the command in hand.
  always_comb begin
    res = '0;
    res.kind = cur.kind;
    if (cur.kind == KIND_DEC) begin
      res.char_out   = cur.char_out;
      res.code_valid = cur.code_valid;
      res.last       = 1'b1;
    end else if (cur_pos < cur.len) begin
      res.symbol_out = cur.bits[cur_pos] ? SYM_DASH : SYM_DOT;
    end else begin
      res.symbol_out = SYM_GAP;
      res.last       = 1'b1;
    end
  end

  // Sequencing and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
      busy      <= !res.last;
      pos       <= cur_pos + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Command and result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
      if (!busy) begin
        cmd <= q_data;
      end
    end
  end

endmodule

FILE: rtl/core/morse_codec.sv
// Morse codec top level. The first result of an item passes through the command
// queue and then the output register. An encoded letter or digit expands into
// its code symbols and a gap, a space into a gap alone, and a decoded character
// into one result, with the back end writing one result per cycle into the output
// register while the output is not stalled. Symbols that produce nothing push no
// command. Reset is synchronous and clears the decoder state, the queue and the
// output valid.
module morse_codec
  import mc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [7:0] char_in, [9:8] symbol_in, rest zero
  input  logic        s_tuser,  // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [1:0] symbol_out, [9:2] char_out, rest zero
  output logic [1:0]  m_tuser,  // [0] kind, [1] code_valid
  output logic        m_tlast
);

  logic       push;
  logic       push_ready;
  mc_cmd_t    push_cmd;
  logic       q_valid;
  logic       q_ready;
  mc_cmd_t    q_data;
  mc_result_t res;

  // Front end: accept and classify.
  mc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tuser),
    .char_in    (s_tdata[7:0]),
    .symbol_in  (s_tdata[9:8]),
    .push       (push),
    .push_ready (push_ready),
    .cmd        (push_cmd)
  );

  // Command queue.
  mc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Back end: expand commands into results.
  mc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Output packing.
  assign m_tdata = {6'd0, res.char_out, res.symbol_out};
  assign m_tuser = {res.code_valid, res.kind};
  assign m_tlast = res.last;

endmodule

FILE: rtl/core/mc_checker.sv
// Port-level checks of the Morse codec, bound to the top level.
// Depends on morse_codec_assert.svh for the assertion macros and on mc_pkg.
`include "morse_codec_assert.svh"

module mc_checker
  import mc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  logic [1:0] sym;
  logic [7:0] ch;
  logic       kind;
  logic       valid;

  // Result fields as unpacked from the output ports.
  assign sym   = m_tdata[1:0];
  assign ch    = m_tdata[9:2];
  assign kind  = m_tuser[0];
  assign valid = m_tuser[1];

  // A stalled result holds.
  `MC_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "stalled result changed")

  // Encoded results carry no character and end exactly on the gap.
  `MC_ASSERT_IMP(a_enc_fields, clk, rst, m_tvalid && kind == KIND_ENC,
    ch == 8'd0 && !valid && ((sym == SYM_GAP) == m_tlast), "bad encoded result")

  // A decoded character is a single last result with no symbol.
  `MC_ASSERT_IMP(a_dec_fields, clk, rst, m_tvalid && kind == KIND_DEC,
    m_tlast && sym == SYM_DOT, "bad decoded result")

  // A valid decoded character is a capital letter or a digit.
  `MC_ASSERT_IMP(a_dec_char, clk, rst, m_tvalid && valid,
    (ch >= CHAR_A && ch <= CHAR_Z) || (ch >= CHAR_ZERO && ch <= CHAR_NINE),
    "decoded character out of range")

endmodule

bind morse_codec mc_checker u_mc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
